>>> design/assert_macros.svh
// Assertion helpers shared by the window datapath modules.
// Both sample on the rising edge of clk and stay quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge.
`define SWSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define SWSA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/swsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swsa_pkg;

  // Window geometry and sample format
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int PTR_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = PTR_W + 1;
  localparam int ENTRY_W     = SAMPLE_BITS + 1;
  localparam int SUM_W       = SAMPLE_BITS + PTR_W;
  localparam int SQ_W        = 2 * SAMPLE_BITS + PTR_W;
  localparam int SQR_W       = 2 * SAMPLE_BITS;

  // Threshold format: unsigned Q4.4
  localparam int THETA_W    = 8;
  localparam int THETA_FRAC = 4;

  // Outlier test datapath widths
  localparam int DIFF_W   = SAMPLE_BITS + 1;
  localparam int DSQ_W    = 2 * SAMPLE_BITS;
  localparam int MSUM_W   = SAMPLE_BITS + SUM_W;
  localparam int MSQ_W    = 2 * SAMPLE_BITS;
  localparam int NMSQ_W   = MSQ_W + CNT_W;
  localparam int DDN_W    = DSQ_W + CNT_W;
  localparam int DEVS_W   = NMSQ_W + 2;
  localparam int DEVU_W   = DSQ_W + CNT_W;
  localparam int LHS_W    = DDN_W + 2 * THETA_FRAC;
  localparam int TT_W     = 2 * THETA_W;
  localparam int DEV_LO_W = DEVU_W / 2;
  localparam int DEV_HI_W = DEVU_W - DEV_LO_W;
  localparam int PLO_W    = TT_W + DEV_LO_W;
  localparam int PHI_W    = TT_W + DEV_HI_W;
  localparam int RHS_W    = TT_W + DEVU_W;
  localparam int CMP_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0]   LEN_RESET   = CNT_W'(16);
  localparam logic [THETA_W-1:0] SIGMA_RESET = THETA_W'(48);

  typedef enum logic [ADDR_W-3:0] {
    REG_WINDOW_LENGTH    = 1'b0,
    REG_SIGMA_MULTIPLIER = 1'b1
  } reg_index_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Settings the front end needs from the register block
  typedef struct packed {
    logic [CNT_W-1:0]   len;
    logic [THETA_W-1:0] theta;
    logic               clear;
  } front_cfg_t;

  // Snapshot of window statistics for one outlier test
  typedef struct packed {
    sample_t                  latest;
    sample_t                  mean;
    logic [CNT_W-1:0]         count;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [SQ_W-1:0]   acc_sq;
    logic [THETA_W-1:0]       theta;
  } job_t;

endpackage

`default_nettype wire

>>> design/swsa_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface swsa_sample_if;
  import swsa_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_value;
  logic    sample_present;
  sample_t window_mean;

  modport source (output valid, output sample_value, output sample_present,
                  output window_mean, input ready);
  modport sink (input valid, input sample_value, input sample_present,
                input window_mean, output ready);
endinterface

`default_nettype wire

>>> design/swsa_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface swsa_result_if;
  import swsa_pkg::*;

  logic             valid;
  logic             ready;
  logic             is_anomaly;
  logic [CNT_W-1:0] values_used;

  modport source (output valid, output is_anomaly, output values_used, input ready);
  modport sink (input valid, input is_anomaly, input values_used, output ready);
endinterface

`default_nettype wire

>>> design/swsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module swsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

>>> design/swsa_front.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module swsa_front (
  input  logic                clk,
  input  logic                rst,
  input  swsa_pkg::front_cfg_t cfg,
  swsa_sample_if.sink         samples,
  output logic                job_valid,
  input  logic                job_ready,
  output swsa_pkg::job_t      job
);
  import swsa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_OLD, S_UPD, S_PUSH} state_t;

  state_t state;

  // Window state
  logic [PTR_W-1:0]        wp;
  logic [CNT_W-1:0]        fill;
  logic [CNT_W-1:0]        pcount;
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [SQ_W-1:0]  acc_sq;
  sample_t                 latest;

  // Current request and the entry it replaces
  sample_t                 x;
  sample_t                 mean;
  logic                    x_pres;
  logic signed [SQR_W-1:0] x_sq;
  sample_t                 ov;
  logic                    ov_pres;
  logic signed [SQR_W-1:0] ov_sq;

  logic                    take;
  logic [PTR_W-1:0]        wp_use;
  logic [CNT_W-1:0]        wp_ext;
  logic [CNT_W-1:0]        wp_inc;
  logic [ENTRY_W-1:0]      rd_data;
  logic [ENTRY_W-1:0]      store_wdata;
  logic                    store_we;
  sample_t                 rd_val;
  logic                    full;
  logic                    drop;
  logic                    emit;
  logic [PTR_W-1:0]        wp_next;
  logic [CNT_W-1:0]        fill_next;
  logic [CNT_W-1:0]        pcount_next;
  logic signed [SUM_W-1:0] sum_drop;
  logic signed [SUM_W-1:0] sum_add;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SQ_W-1:0]  sq_drop;
  logic signed [SQ_W-1:0]  sq_add;
  logic signed [SQ_W-1:0]  sq_next;
  sample_t                 latest_next;

  assign samples.ready = (state == S_IDLE);
  assign take          = samples.valid && samples.ready;
  assign job_valid     = (state == S_PUSH);

  // Guard the pointer against a length below it
  assign wp_ext = CNT_W'(wp);
  assign wp_use = (wp_ext >= cfg.len) ? '0 : wp;
  assign wp_inc = CNT_W'(wp_use) + CNT_W'(1);

  assign rd_val      = rd_data[SAMPLE_BITS-1:0];
  assign store_we    = (state == S_UPD);
  assign store_wdata = {x_pres, x};

  swsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (wp_use),
    .wdata (store_wdata),
    .re    (take),
    .raddr (wp_use),
    .rdata (rd_data)
  );

  // Retire the oldest entry and fold in the new one
  always_comb begin
    full = (fill >= cfg.len);
    drop = full && ov_pres;

    sum_drop = '0;
    sq_drop  = '0;
    if (drop) begin
      sum_drop = SUM_W'(ov);
      sq_drop  = SQ_W'(ov_sq);
    end
    sum_add = '0;
    sq_add  = '0;
    if (x_pres) begin
      sum_add = SUM_W'(x);
      sq_add  = SQ_W'(x_sq);
    end
    sum_next = acc_sum - sum_drop + sum_add;
    sq_next  = acc_sq - sq_drop + sq_add;

    pcount_next = pcount;
    if (drop && (pcount != '0)) begin
      pcount_next = pcount_next - CNT_W'(1);
    end
    if (x_pres) begin
      pcount_next = pcount_next + CNT_W'(1);
    end

    fill_next   = full ? fill : fill + CNT_W'(1);
    latest_next = x_pres ? x : latest;
    wp_next     = (wp_inc >= cfg.len) ? '0 : wp_inc[PTR_W-1:0];
    emit        = (fill_next >= cfg.len) && (pcount_next != '0);
  end

  // Sequence one request: read old entry, update, hand off
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wp      <= '0;
      fill    <= '0;
      pcount  <= '0;
      acc_sum <= '0;
      acc_sq  <= '0;
      latest  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_OLD;
          end
        end
        S_OLD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state <= emit ? S_PUSH : S_IDLE;
        end
        S_PUSH: begin
          if (job_ready) begin
            state <= S_IDLE;
          end
        end
      endcase
      // A new window length restarts the window
      if (cfg.clear) begin
        wp      <= '0;
        fill    <= '0;
        pcount  <= '0;
        acc_sum <= '0;
        acc_sq  <= '0;
        latest  <= '0;
      end else if (state == S_UPD) begin
        wp      <= wp_next;
        fill    <= fill_next;
        pcount  <= pcount_next;
        acc_sum <= sum_next;
        acc_sq  <= sq_next;
        latest  <= latest_next;
      end
    end
  end

  // Hold the request payload and build the job
  always_ff @(posedge clk) begin
    if (take) begin
      x      <= samples.sample_value;
      mean   <= samples.window_mean;
      x_pres <= samples.sample_present;
      x_sq   <= SQR_W'(samples.sample_value) * SQR_W'(samples.sample_value);
    end
    if (state == S_OLD) begin
      ov      <= rd_val;
      ov_pres <= rd_data[SAMPLE_BITS];
      ov_sq   <= SQR_W'(rd_val) * SQR_W'(rd_val);
    end
    if (state == S_UPD) begin
      job.latest  <= latest_next;
      job.mean    <= mean;
      job.count   <= pcount_next;
      job.acc_sum <= sum_next;
      job.acc_sq  <= sq_next;
      job.theta   <= cfg.theta;
    end
  end

  `SWSA_ASSERT(a_count_le_fill, pcount <= fill, "present count exceeds window fill")
  `SWSA_ASSERT_IMPL(a_ptr_tracks_fill, fill < cfg.len, wp_ext == fill, "pointer off fill")

endmodule

`default_nettype wire

>>> design/swsa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module swsa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  swsa_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output swsa_pkg::job_t pop_job
);
  import swsa_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `SWSA_ASSERT_IMPL(a_empty_ptrs, count == '0, rd_ptr == wr_ptr, "empty queue, pointers apart")

endmodule

`default_nettype wire

>>> design/swsa_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module swsa_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  swsa_pkg::job_t job,
  swsa_result_if.source  results
);
  import swsa_pkg::*;

  localparam int DPROD_W = 2 * DIFF_W;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL1, B_MUL2, B_DEV, B_PART, B_SUM, B_CMP
  } state_t;

  state_t state;
  job_t   j;

  logic                     out_valid;
  logic                     out_anom;
  logic [CNT_W-1:0]         out_used;

  logic signed [DIFF_W-1:0]  diff_c;
  logic signed [DPROD_W-1:0] dprod_c;
  logic signed [MSUM_W-1:0]  msum_c;
  logic signed [MSQ_W-1:0]   msq_c;
  logic signed [DEVS_W-1:0]  dev_c;
  logic                      anom_c;

  logic [DSQ_W-1:0]          d_sq;
  logic signed [MSUM_W-1:0]  m_sum;
  logic [MSQ_W-1:0]          m_sq;
  logic [TT_W-1:0]           tt;
  logic [NMSQ_W-1:0]         n_msq;
  logic [DDN_W-1:0]          dd_n;
  logic [DEVU_W-1:0]         dev;
  logic [LHS_W-1:0]          lhs;
  logic [PLO_W-1:0]          p_lo;
  logic [PHI_W-1:0]          p_hi;
  logic [RHS_W-1:0]          rhs;

  assign job_ready          = (state == B_IDLE);
  assign results.valid      = out_valid;
  assign results.is_anomaly = out_anom;
  assign results.values_used = out_used;

  // Per-step arithmetic, one multiply deep
  assign diff_c  = DIFF_W'(j.latest) - DIFF_W'(j.mean);
  assign dprod_c = DPROD_W'(diff_c) * DPROD_W'(diff_c);
  assign msum_c  = MSUM_W'(j.mean) * MSUM_W'(j.acc_sum);
  assign msq_c   = MSQ_W'(j.mean) * MSQ_W'(j.mean);
  assign dev_c   = DEVS_W'(j.acc_sq) - (DEVS_W'(m_sum) <<< 1) + DEVS_W'(n_msq);
  assign anom_c  = CMP_W'(lhs) >= CMP_W'(rhs);

  // Step through the squared sigma test
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once taken
      if ((state == B_CMP) && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            state <= B_MUL1;
          end
        end
        B_MUL1: state <= B_MUL2;
        B_MUL2: state <= B_DEV;
        B_DEV:  state <= B_PART;
        B_PART: state <= B_SUM;
        B_SUM:  state <= B_CMP;
        B_CMP: begin
          // Load the result once the output register is free
          if (!out_valid || results.ready) begin
            out_anom  <= anom_c;
            out_used  <= j.count;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      j <= job;
    end
    if (state == B_MUL1) begin
      d_sq  <= dprod_c[DSQ_W-1:0];
      m_sum <= msum_c;
      m_sq  <= msq_c;
      tt    <= TT_W'(j.theta) * TT_W'(j.theta);
    end
    if (state == B_MUL2) begin
      n_msq <= NMSQ_W'(m_sq) * NMSQ_W'(j.count);
      dd_n  <= DDN_W'(d_sq) * DDN_W'(j.count);
    end
    if (state == B_DEV) begin
      dev <= dev_c[DEVU_W-1:0];
      lhs <= {dd_n, {(2 * THETA_FRAC){1'b0}}};
    end
    if (state == B_PART) begin
      p_lo <= PLO_W'(tt) * PLO_W'(dev[DEV_LO_W-1:0]);
      p_hi <= PHI_W'(tt) * PHI_W'(dev[DEVU_W-1:DEV_LO_W]);
    end
    if (state == B_SUM) begin
      rhs <= (RHS_W'(p_hi) << DEV_LO_W) + RHS_W'(p_lo);
    end
  end

  `SWSA_ASSERT_IMPL(a_dev_nonneg, state == B_DEV, !dev_c[DEVS_W-1], "negative deviation sum")

endmodule

`default_nettype wire

>>> design/sliding_window_sigma_anomaly_top.sv
// Sliding-window sigma outlier test for one sensor stream.
// samples: valid/ready channel carrying sample_value (Q8.8), sample_present
//   and window_mean (Q8.8); taken when valid and ready are both high.
// results: valid/ready channel carrying is_anomaly and values_used; one result
//   per sample once the window is full and holds a present sample.
// APB port: 0x0 window_length (1..64, reset 16; a write restarts the window),
//   0x4 sigma_multiplier (Q4.4, reset 48). pready is tied high.
// Timing: the front end takes a new sample only once its read-update pass over
//   the window RAM for the last one is done and any job it yields is handed off.
//   The test runs as steps of chained multiplies (MUL1, MUL2, DEV, PART, SUM,
//   CMP) and takes a new job only once the last has left the CMP step; a
//   4-entry job queue sits between the two.
// Reset: synchronous, clears the window, counts and sums, and loads the
//   register defaults. The window RAM needs no clearing pass.
// Stall: the result register holds until taken; the queue then fills and
//   samples.ready drops until room frees up.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_sigma_anomaly_top (
  input  logic                          clk,
  input  logic                          rst,
  swsa_sample_if.sink                   samples,
  swsa_result_if.source                 results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swsa_pkg::ADDR_W-1:0]   paddr,
  input  logic [swsa_pkg::DATA_W-1:0]   pwdata,
  output logic [swsa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import swsa_pkg::*;

  logic [CNT_W-1:0]   window_length;
  logic [THETA_W-1:0] sigma_multiplier;
  logic               wr;
  reg_index_t         reg_sel;
  logic [CNT_W-1:0]   len_eff;
  front_cfg_t         cfg;
  logic               job_valid;
  logic               job_ready;
  job_t               job;
  logic               q_valid;
  logic               q_ready;
  job_t               q_job;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = reg_index_t'(paddr[ADDR_W-1:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= LEN_RESET;
      sigma_multiplier <= SIGMA_RESET;
    end else if (wr) begin
      unique case (reg_sel)
        REG_WINDOW_LENGTH:    window_length    <= pwdata[CNT_W-1:0];
        REG_SIGMA_MULTIPLIER: sigma_multiplier <= pwdata[THETA_W-1:0];
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_sel)
      REG_WINDOW_LENGTH:    prdata = DATA_W'(window_length);
      REG_SIGMA_MULTIPLIER: prdata = DATA_W'(sigma_multiplier);
    endcase
  end

  // Clamp the window length to 1..MAX_WINDOW
  always_comb begin
    if (window_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (window_length > CNT_W'(MAX_WINDOW)) begin
      len_eff = CNT_W'(MAX_WINDOW);
    end else begin
      len_eff = window_length;
    end
  end

  assign cfg.len   = len_eff;
  assign cfg.theta = sigma_multiplier;
  assign cfg.clear = wr && (reg_sel == REG_WINDOW_LENGTH);

  swsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .samples   (samples),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  swsa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_job   (job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  swsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .results   (results)
  );

endmodule

`default_nettype wire
